// ===== rtl/dbfs_pkg.sv =====
// Shared types and constants for the display brightness fade sequencer.
// Depends on nothing; imported by every module of the block.
package dbfs_pkg;

    // Field widths
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned LEVEL_W     = 7;
    localparam int unsigned SLIDE_W     = 3;
    localparam int unsigned DWELL_W     = 11;
    localparam int unsigned CFG_IDX_W   = 1;

    // Low sample bits dropped before averaging
    localparam int unsigned SAMPLE_DROP = 3;

    // Dwell counter saturation value
    localparam logic [DWELL_W-1:0] DWELL_MAX = '1;

    // Register reset values
    localparam logic [DWELL_W-1:0] DWELL_LONG_RST  = DWELL_W'(1000);
    localparam logic [DWELL_W-1:0] DWELL_SHORT_RST = DWELL_W'(50);

    // Parameter defaults
    localparam int unsigned SMOOTH_DEPTH_DEF = 8;
    localparam int unsigned LAST_SLIDE_DEF   = 5;

    // Event codes
    typedef enum logic [KIND_W-1:0] {
        KIND_BRIGHT = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_PREV   = 2'd2,
        KIND_NEXT   = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DWELL_LONG  = 1'b0,
        CFG_DWELL_SHORT = 1'b1
    } cfg_idx_t;

    // One captured event
    typedef struct packed {
        kind_t               kind;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

endpackage

// ===== rtl/dbfs_input_stage.sv =====
// Input register of the fade sequencer: captures one event transaction.
// Depends on dbfs_pkg.
module dbfs_input_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dbfs_pkg::KIND_W-1:0]   kind,
    input  logic [dbfs_pkg::SAMPLE_W-1:0] light_sample,
    output logic                          item_valid,
    output dbfs_pkg::item_t               item,
    input  logic                          item_take
);
    import dbfs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Register is free when empty or being drained this cycle
    assign in_ready = !valid_reg || item_take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind   <= kind_t'(kind);
            item_reg.sample <= light_sample;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/dbfs_light_filter.sv =====
// Ambient light smoothing: avg + floor((s - avg) / SMOOTH_DEPTH), which equals
// (avg*(SMOOTH_DEPTH-1) + s) / SMOOTH_DEPTH. Depends on dbfs_pkg.
module dbfs_light_filter #(
    parameter int unsigned SMOOTH_DEPTH = dbfs_pkg::SMOOTH_DEPTH_DEF
) (
    input  logic [dbfs_pkg::LEVEL_W-1:0]  avg,
    input  logic [dbfs_pkg::SAMPLE_W-1:0] sample,
    output logic [dbfs_pkg::LEVEL_W-1:0]  avg_next
);
    import dbfs_pkg::*;

    // Reciprocal multiply, exact for any numerator below 2^NUM_W
    localparam int unsigned NUM_W   = LEVEL_W + 1;
    localparam int unsigned SHIFT   = NUM_W + $clog2(SMOOTH_DEPTH);
    localparam int unsigned RECIP   = ((1 << SHIFT) + SMOOTH_DEPTH - 1) / SMOOTH_DEPTH;
    localparam int unsigned PROD_W  = SHIFT + NUM_W;
    localparam logic [NUM_W-1:0] DEPTH_M1 = NUM_W'(SMOOTH_DEPTH - 1);

    logic [LEVEL_W-1:0] level;
    logic               neg;
    logic [LEVEL_W-1:0] mag;
    logic [NUM_W-1:0]   numer;
    logic [PROD_W-1:0]  prod;
    logic [LEVEL_W-1:0] quot;

    assign level = sample[SAMPLE_DROP +: LEVEL_W];
    assign neg   = level < avg;
    assign mag   = neg ? (avg - level) : (level - avg);

    // Negative difference rounds away from zero: ceil via +N-1
    assign numer = {1'b0, mag} + (neg ? DEPTH_M1 : '0);
    assign prod  = PROD_W'(numer) * PROD_W'(RECIP);
    assign quot  = prod[SHIFT +: LEVEL_W];

    assign avg_next = neg ? (avg - quot) : (avg + quot);

endmodule

// ===== rtl/dbfs_seq_core.sv =====
// Sequencer state: light average, drive level, fade flags, slide and dwell
// counter, plus the dwell registers. Depends on dbfs_pkg, dbfs_light_filter.
module dbfs_seq_core #(
    parameter int unsigned SMOOTH_DEPTH = dbfs_pkg::SMOOTH_DEPTH_DEF,
    parameter int unsigned LAST_SLIDE   = dbfs_pkg::LAST_SLIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  dbfs_pkg::item_t                item,
    output logic                           item_take,
    input  logic                           cfg_valid,
    input  logic [dbfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dbfs_pkg::DWELL_W-1:0]   cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dbfs_pkg::LEVEL_W-1:0]   drive_level,
    output logic [dbfs_pkg::LEVEL_W-1:0]   smoothed_light,
    output logic [dbfs_pkg::SLIDE_W-1:0]   slide_index,
    output logic                           fading_out,
    output logic                           fading_in
);
    import dbfs_pkg::*;

    localparam logic [SLIDE_W:0] LAST_W = (SLIDE_W+1)'(LAST_SLIDE);

    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] avg_reg, avg_next;
    logic [LEVEL_W-1:0] drive_reg, drive_next;
    logic               down_reg, down_next;
    logic               up_reg, up_next;
    logic [SLIDE_W-1:0] slide_reg, slide_next;
    logic [DWELL_W-1:0] count_reg, count_next;
    logic [DWELL_W-1:0] dwell_long_reg, dwell_short_reg;

    logic               fire;
    logic [LEVEL_W-1:0] avg_filt;
    logic [SLIDE_W:0]   fwd_raw;
    logic [SLIDE_W-1:0] slide_fwd, slide_back;
    logic [DWELL_W-1:0] count_inc;
    logic [DWELL_W-1:0] limit;

    // Result register free when empty or taken this cycle
    assign item_take = item_valid && (!out_valid_reg || out_ready);
    assign fire      = item_take;

    dbfs_light_filter #(
        .SMOOTH_DEPTH (SMOOTH_DEPTH)
    ) u_filter (
        .avg      (avg_reg),
        .sample   (item.sample),
        .avg_next (avg_filt)
    );

    // Slide wrap in both directions
    assign fwd_raw    = {1'b0, slide_reg} + 1'b1;
    assign slide_fwd  = (fwd_raw > LAST_W) ? '0 : fwd_raw[SLIDE_W-1:0];
    assign slide_back = (slide_reg == '0) ? LAST_W[SLIDE_W-1:0]
                      : (({1'b0, slide_reg} - 1'b1) > LAST_W) ? '0 : (slide_reg - 1'b1);

    // Saturating dwell count and limit for the current slide
    assign count_inc = (count_reg < DWELL_MAX) ? (count_reg + 1'b1) : count_reg;
    assign limit     = (slide_reg == '0) ? dwell_long_reg : dwell_short_reg;

    // Next state for one event
    always_comb
    begin
        avg_next   = avg_reg;
        drive_next = drive_reg;
        down_next  = down_reg;
        up_next    = up_reg;
        slide_next = slide_reg;
        count_next = count_reg;
        case (item.kind)
            KIND_BRIGHT:
            begin
                avg_next = avg_filt;
                if (down_reg)
                begin
                    if (drive_reg != '0)
                    begin
                        drive_next = drive_reg - 1'b1;
                    end
                    else
                    begin
                        slide_next = slide_fwd;
                        count_next = '0;
                        down_next  = 1'b0;
                        up_next    = 1'b1;
                        drive_next = '0;
                    end
                end
                else if (up_reg)
                begin
                    if (drive_reg < avg_filt)
                    begin
                        drive_next = drive_reg + 1'b1;
                    end
                    else
                    begin
                        up_next = 1'b0;
                    end
                end
                else
                begin
                    drive_next = (avg_filt != '0) ? avg_filt : LEVEL_W'(1);
                end
            end
            KIND_FRAME:
            begin
                count_next = count_inc;
                if (count_inc > limit)
                begin
                    down_next = 1'b1;
                end
            end
            KIND_PREV:
            begin
                slide_next = slide_back;
                count_next = '0;
                down_next  = 1'b0;
                up_next    = 1'b1;
                drive_next = '0;
            end
            default:
            begin
                slide_next = slide_fwd;
                count_next = '0;
                down_next  = 1'b0;
                up_next    = 1'b1;
                drive_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
            drive_reg     <= '0;
            down_reg      <= 1'b0;
            up_reg        <= 1'b0;
            slide_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                avg_reg   <= avg_next;
                drive_reg <= drive_next;
                down_reg  <= down_next;
                up_reg    <= up_next;
                slide_reg <= slide_next;
                count_reg <= count_next;
            end
        end
    end

    // Dwell limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_long_reg  <= DWELL_LONG_RST;
            dwell_short_reg <= DWELL_SHORT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DWELL_LONG:  dwell_long_reg  <= cfg_data;
                CFG_DWELL_SHORT: dwell_short_reg <= cfg_data;
                default:         dwell_long_reg  <= dwell_long_reg;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_level    = drive_reg;
    assign smoothed_light = avg_reg;
    assign slide_index    = slide_reg;
    assign fading_out     = down_reg;
    assign fading_in      = up_reg;

endmodule

// ===== rtl/display_brightness_fade_sequencer_unit.sv =====
// Top level of the display brightness fade sequencer.
// Depends on dbfs_pkg, dbfs_input_stage, dbfs_seq_core.
//
// Usage:
//   Event channel (in_valid/in_ready, kind, light_sample): one transaction per
//   brightness tick, frame tick, previous or next slide request.
//   Result channel (out_valid/out_ready): one transaction per event, carrying
//   drive level, smoothed light, slide index and both fade flags after it.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): dwell_long at
//   index 0, dwell_short at index 1; always ready, write only while idle.
// Path: an accepted event passes the input register, then the state/result
//   register, with one reciprocal multiply between.
// Throughput: one event per cycle when the receiver takes every result.
// Reset: all sequencer state clears, dwell limits return to 1000 and 50, and
//   both channels come up empty.
// Stall: a held result keeps its values; one more event can wait in the input
//   register, after which in_ready drops until out_ready returns.
module display_brightness_fade_sequencer_unit #(
    parameter int unsigned SMOOTH_DEPTH = dbfs_pkg::SMOOTH_DEPTH_DEF,
    parameter int unsigned LAST_SLIDE   = dbfs_pkg::LAST_SLIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dbfs_pkg::KIND_W-1:0]    kind,
    input  logic [dbfs_pkg::SAMPLE_W-1:0]  light_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dbfs_pkg::LEVEL_W-1:0]   drive_level,
    output logic [dbfs_pkg::LEVEL_W-1:0]   smoothed_light,
    output logic [dbfs_pkg::SLIDE_W-1:0]   slide_index,
    output logic                           fading_out,
    output logic                           fading_in,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dbfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dbfs_pkg::DWELL_W-1:0]   cfg_data
);
    import dbfs_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_take;

    assign cfg_ready = 1'b1;

    dbfs_input_stage u_input (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .light_sample (light_sample),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    dbfs_seq_core #(
        .SMOOTH_DEPTH (SMOOTH_DEPTH),
        .LAST_SLIDE   (LAST_SLIDE)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_level    (drive_level),
        .smoothed_light (smoothed_light),
        .slide_index    (slide_index),
        .fading_out     (fading_out),
        .fading_in      (fading_in)
    );

    // Slide index never leaves the configured range
    a_slide_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slide_index <= (SLIDE_W)'(LAST_SLIDE)))
        else $error("slide index beyond last slide");

    // Input backpressure only when a result is held and the input register is full
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid && out_valid && !out_ready))
        else $error("input stalled without a held result");

    // An event in the input register moves on whenever the result side is free
    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && (!out_valid || out_ready)) |=> out_valid)
        else $error("event did not produce a result");

endmodule
